@@ src/first_order_ladrc_rate_controller_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the first-order LADRC rate controller
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_ORDER_LADRC_RATE_CONTROLLER_ASSERT_SVH
`define FIRST_ORDER_LADRC_RATE_CONTROLLER_ASSERT_SVH

// Same-cycle implication
`define LADRC_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (expr)) else $error(msg);

// Next-cycle implication
`define LADRC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expr)) else $error(msg);

`endif

@@ src/ladrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ladrc_pkg
// Types, defaults, register indexes and the microcode program of the
// first-order LADRC rate controller.
// ----------------------------------------------------------------------------
package ladrc_pkg;

    // Datapath defaults
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Configuration port
    localparam int CFG_W      = 31;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_TIME          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PLANT_GAIN         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTROL_BANDWIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_OBSERVER_BANDWIDTH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DISTURBANCE_LIMIT  = 3'd5;

    localparam logic [CFG_W-1:0] DEF_STEP_TIME          = 31'd328;
    localparam logic [CFG_W-1:0] DEF_PLANT_GAIN         = 31'd1310720;
    localparam logic [CFG_W-1:0] DEF_CONTROL_BANDWIDTH  = 31'd655360;
    localparam logic [CFG_W-1:0] DEF_OBSERVER_BANDWIDTH = 31'd1966080;
    localparam logic [CFG_W-1:0] DEF_OUTPUT_LIMIT       = 31'd19660800;
    localparam logic [CFG_W-1:0] DEF_DISTURBANCE_LIMIT  = 31'd393216000;

    // Microcode program counter
    localparam int UPC_W = 6;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_IDLE  = 6'd0;
    localparam upc_t UPC_EMIT  = 6'd34;
    localparam upc_t UPC_CLEAR = 6'd35;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADD,
        OP_SUB,
        OP_CLAMP,
        OP_MULA,   // latch operand magnitudes and product sign
        OP_MULL,   // low partial product
        OP_MULH,   // high partial product, accumulate
        OP_DIVI,   // set up quotient, overflow check
        OP_DIVS,   // one quotient bit
        OP_CLR     // zero the loop state
    } op_t;

    // Sequencing
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_START,  // wait for an item, branch on action
        SEQ_LOOP,   // repeat while the divider runs
        SEQ_EMIT,   // wait for a free output register
        SEQ_JUMP
    } seq_t;

    // Operand sources
    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_Y,
        SRC_R,
        SRC_Z1,
        SRC_Z2,
        SRC_U,
        SRC_E,
        SRC_T,
        SRC_B2,
        SRC_ERR,
        SRC_P,
        SRC_Q,
        SRC_TS,
        SRC_B0,
        SRC_WC,
        SRC_WO,
        SRC_B1,
        SRC_OL,
        SRC_DL
    } src_t;

    // Result destinations
    typedef enum logic [2:0] {
        DST_NONE,
        DST_Z1,
        DST_Z2,
        DST_U,
        DST_E,
        DST_T,
        DST_B2,
        DST_ERR
    } dst_t;

    typedef struct packed {
        op_t  op;
        seq_t seq;
        src_t src_a;
        src_t src_b;
        dst_t dst;
        upc_t addr;
    } uc_word_t;

    function automatic uc_word_t uw(op_t op, seq_t sq, src_t a, src_t b, dst_t d, upc_t t);
        uw = '{op: op, seq: sq, src_a: a, src_b: b, dst: d, addr: t};
    endfunction

    // Control store: one word per step
    function automatic uc_word_t uc_rom(upc_t pc);
        uc_word_t w;
        unique case (pc)
            // idle, take an item
            6'd0:  w = uw(OP_NOP,   SEQ_START, SRC_ZERO, SRC_ZERO, DST_NONE, UPC_CLEAR);
            // e = y - z1
            6'd1:  w = uw(OP_SUB,   SEQ_NEXT,  SRC_Y,    SRC_Z1,   DST_E,    UPC_IDLE);
            // beta2 = wo * wo
            6'd2:  w = uw(OP_MULA,  SEQ_NEXT,  SRC_WO,   SRC_WO,   DST_NONE, UPC_IDLE);
            6'd3:  w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd4:  w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd5:  w = uw(OP_ADD,   SEQ_NEXT,  SRC_P,    SRC_ZERO, DST_B2,   UPC_IDLE);
            // term = z2 + b0 * u_prev
            6'd6:  w = uw(OP_MULA,  SEQ_NEXT,  SRC_B0,   SRC_U,    DST_NONE, UPC_IDLE);
            6'd7:  w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd8:  w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd9:  w = uw(OP_ADD,   SEQ_NEXT,  SRC_Z2,   SRC_P,    DST_T,    UPC_IDLE);
            // term += beta1 * e
            6'd10: w = uw(OP_MULA,  SEQ_NEXT,  SRC_B1,   SRC_E,    DST_NONE, UPC_IDLE);
            6'd11: w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd12: w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd13: w = uw(OP_ADD,   SEQ_NEXT,  SRC_T,    SRC_P,    DST_T,    UPC_IDLE);
            // z1 += Ts * term
            6'd14: w = uw(OP_MULA,  SEQ_NEXT,  SRC_TS,   SRC_T,    DST_NONE, UPC_IDLE);
            6'd15: w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd16: w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd17: w = uw(OP_ADD,   SEQ_NEXT,  SRC_Z1,   SRC_P,    DST_Z1,   UPC_IDLE);
            // z2 += Ts * (beta2 * e), then clamp
            6'd18: w = uw(OP_MULA,  SEQ_NEXT,  SRC_B2,   SRC_E,    DST_NONE, UPC_IDLE);
            6'd19: w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd20: w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd21: w = uw(OP_MULA,  SEQ_NEXT,  SRC_TS,   SRC_P,    DST_NONE, UPC_IDLE);
            6'd22: w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd23: w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd24: w = uw(OP_ADD,   SEQ_NEXT,  SRC_Z2,   SRC_P,    DST_Z2,   UPC_IDLE);
            6'd25: w = uw(OP_CLAMP, SEQ_NEXT,  SRC_Z2,   SRC_DL,   DST_Z2,   UPC_IDLE);
            // err = r - z1
            6'd26: w = uw(OP_SUB,   SEQ_NEXT,  SRC_R,    SRC_Z1,   DST_ERR,  UPC_IDLE);
            // num = wc * err - z2
            6'd27: w = uw(OP_MULA,  SEQ_NEXT,  SRC_WC,   SRC_ERR,  DST_NONE, UPC_IDLE);
            6'd28: w = uw(OP_MULL,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd29: w = uw(OP_MULH,  SEQ_NEXT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd30: w = uw(OP_SUB,   SEQ_NEXT,  SRC_P,    SRC_Z2,   DST_T,    UPC_IDLE);
            // u = clamp(num / b0)
            6'd31: w = uw(OP_DIVI,  SEQ_NEXT,  SRC_T,    SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd32: w = uw(OP_DIVS,  SEQ_LOOP,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            6'd33: w = uw(OP_CLAMP, SEQ_NEXT,  SRC_Q,    SRC_OL,   DST_U,    UPC_IDLE);
            // hand the result over
            6'd34: w = uw(OP_NOP,   SEQ_EMIT,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
            // clear action
            6'd35: w = uw(OP_CLR,   SEQ_JUMP,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_EMIT);
            default: w = uw(OP_NOP, SEQ_JUMP,  SRC_ZERO, SRC_ZERO, DST_NONE, UPC_IDLE);
        endcase
        return w;
    endfunction

endpackage

@@ src/first_order_ladrc_rate_controller.sv @@
// ----------------------------------------------------------------------------
// first_order_ladrc_rate_controller
// First-order linear active disturbance rejection rate controller. Each item
// carries a target and a measured rate; the extended state observer updates
// the rate and disturbance estimates from the output kept from the previous
// item, and the law (wc*(r - z1) - z2) / b0, clamped, gives the new output.
// A clear item zeroes the loop state and returns all-zero fields. Data are
// signed fixed point with FRAC_BITS fraction bits, saturated to DATA_WIDTH.
// A control item runs through the microcoded sequencer: seven products on one
// shared multiplier at three steps each, then a restoring divider that yields
// one quotient bit per cycle; a clear item takes only the clear and emit
// steps. The result register lets the next item enter while a result still
// waits to be taken; the sequencer holds only if a second result is ready
// before the first has gone.
// ----------------------------------------------------------------------------
`include "first_order_ladrc_rate_controller_assert.svh"

module first_order_ladrc_rate_controller
    import ladrc_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration writes
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_W-1:0]         cfg_wdata,
    // input items
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_action,
    input  logic signed [31:0]       s_target_rate,
    input  logic signed [31:0]       s_measured_rate,
    // result items
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_control_output,
    output logic signed [31:0]       m_rate_estimate,
    output logic signed [31:0]       m_disturbance_estimate,
    output logic signed [31:0]       m_tracking_error
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int OW = (DW > 32) ? DW : 32;   // operand width, holds data and config
    localparam int HW = (OW + 1) / 2;          // partial product slice
    localparam int PW = 2 * OW;                // product accumulator
    localparam int CW = $clog2(DW);            // divider step count

    localparam logic signed [OW:0] SAT_HI = $signed({{(OW-DW+2){1'b0}}, {(DW-1){1'b1}}});
    localparam logic signed [OW:0] SAT_LO = $signed({{(OW-DW+2){1'b1}}, {(DW-1){1'b0}}});
    localparam logic signed [DW-1:0] D_HI = $signed({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [DW-1:0] D_LO = $signed({1'b1, {(DW-1){1'b0}}});
    localparam logic signed [OW:0] O32_HI = (OW+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [OW:0] O32_LO = (OW+1)'(33'sh1_8000_0000);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] ts_reg, b0_reg, wc_reg, wo_reg, ol_reg, dl_reg;

    upc_t pc_reg, pc_next;

    logic signed [DW-1:0] z1_reg, z1_next, z2_reg, z2_next, u_reg, u_next;
    logic signed [DW-1:0] r_reg, r_next, y_reg, y_next;
    logic signed [DW-1:0] e_reg, e_next, t_reg, t_next, b2_reg, b2_next;
    logic signed [DW-1:0] err_reg, err_next;

    logic          mneg_reg, mneg_next;
    logic [OW-1:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [PW-1:0] acc_reg, acc_next;

    logic            dneg_reg, dneg_next, dzero_reg, dzero_next, dovf_reg, dovf_next;
    logic [CFG_W-1:0] rem_reg, rem_next;
    logic [DW-2:0]   qsh_reg, qsh_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic signed [31:0]    uo_reg, uo_next, z1o_reg, z1o_next;
    logic signed [31:0]    z2o_reg, z2o_next, erro_reg, erro_next;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    uc_word_t uc;
    logic     in_fire, out_free, out_load;

    logic signed [OW-1:0] a_w, b_w;
    logic [OW-1:0]        a_mag, b_mag;
    logic signed [OW:0]   add_x, sub_x, a_x, lim_x, clamp_x;
    logic signed [DW-1:0] alu_res, beta1, p_val, q_val;
    logic                 alu_wr;

    logic [HW-1:0]        m_b;
    logic [OW+HW-1:0]     pp;
    logic                 p_ovf;
    logic [DW-2:0]        p_mag;

    logic [DW+F-1:0]      dd;
    logic [F:0]           r_init;
    logic [CFG_W:0]       trial;
    logic                 ge;

    // Saturate to the data range
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [OW:0] v);
        if (v > SAT_HI) begin
            return D_HI;
        end else if (v < SAT_LO) begin
            return D_LO;
        end
        return v[DW-1:0];
    endfunction

    // Saturate a data value to the 32-bit result fields
    function automatic logic signed [31:0] out32(input logic signed [DW-1:0] v);
        logic signed [OW:0] vx;
        vx = (OW+1)'(v);
        if (vx > O32_HI) begin
            return 32'sh7FFF_FFFF;
        end else if (vx < O32_LO) begin
            return 32'sh8000_0000;
        end
        return vx[31:0];
    endfunction

    // Operand select
    function automatic logic signed [OW-1:0] operand(input src_t sel);
        logic signed [OW-1:0] v;
        unique case (sel)
            SRC_ZERO: v = '0;
            SRC_Y:    v = OW'(y_reg);
            SRC_R:    v = OW'(r_reg);
            SRC_Z1:   v = OW'(z1_reg);
            SRC_Z2:   v = OW'(z2_reg);
            SRC_U:    v = OW'(u_reg);
            SRC_E:    v = OW'(e_reg);
            SRC_T:    v = OW'(t_reg);
            SRC_B2:   v = OW'(b2_reg);
            SRC_ERR:  v = OW'(err_reg);
            SRC_P:    v = OW'(p_val);
            SRC_Q:    v = OW'(q_val);
            SRC_TS:   v = $signed(OW'(ts_reg));
            SRC_B0:   v = $signed(OW'(b0_reg));
            SRC_WC:   v = $signed(OW'(wc_reg));
            SRC_WO:   v = $signed(OW'(wo_reg));
            SRC_B1:   v = OW'(beta1);
            SRC_OL:   v = $signed(OW'(ol_reg));
            SRC_DL:   v = $signed(OW'(dl_reg));
            default:  v = '0;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign uc       = uc_rom(pc_reg);
    assign s_ready  = (uc.seq == SEQ_START);
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (uc.seq == SEQ_EMIT) && out_free;

    // Next step
    always_comb begin
        unique case (uc.seq)
            SEQ_NEXT:  pc_next = pc_reg + 1'b1;
            SEQ_START: begin
                if (!s_valid) begin
                    pc_next = pc_reg;
                end else if (s_action) begin
                    pc_next = uc.addr;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            SEQ_LOOP:  pc_next = (cnt_reg == CW'(1)) ? pc_reg + 1'b1 : pc_reg;
            SEQ_EMIT:  pc_next = out_free ? uc.addr : pc_reg;
            SEQ_JUMP:  pc_next = uc.addr;
            default:   pc_next = UPC_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    assign a_w   = operand(uc.src_a);
    assign b_w   = operand(uc.src_b);
    assign a_mag = a_w[OW-1] ? OW'(-a_w) : OW'(a_w);
    assign b_mag = b_w[OW-1] ? OW'(-b_w) : OW'(b_w);

    // Doubled observer bandwidth
    assign beta1 = sat_dw($signed((OW+1)'({1'b0, wo_reg, 1'b0})));

    // Saturating add, subtract and symmetric clamp
    assign add_x   = (OW+1)'(a_w) + (OW+1)'(b_w);
    assign sub_x   = (OW+1)'(a_w) - (OW+1)'(b_w);
    assign a_x     = (OW+1)'(a_w);
    assign lim_x   = ((OW+1)'(b_w) > SAT_HI) ? SAT_HI : (OW+1)'(b_w);
    assign clamp_x = (a_x > lim_x) ? lim_x : ((a_x < -lim_x) ? -lim_x : a_x);

    always_comb begin
        unique case (uc.op)
            OP_ADD:   alu_res = sat_dw(add_x);
            OP_SUB:   alu_res = sat_dw(sub_x);
            OP_CLAMP: alu_res = clamp_x[DW-1:0];
            default:  alu_res = '0;
        endcase
    end
    assign alu_wr = (uc.op == OP_ADD) || (uc.op == OP_SUB) || (uc.op == OP_CLAMP);

    // Shared multiplier: one slice of the second operand per step
    assign m_b = (uc.op == OP_MULH) ? HW'(mb_reg[OW-1:HW]) : mb_reg[HW-1:0];
    assign pp  = (OW+HW)'(ma_reg) * (OW+HW)'(m_b);

    // Drop fraction bits and saturate the product
    assign p_ovf = |acc_reg[PW-1:DW-1+F];
    assign p_mag = acc_reg[DW-2+F:F];
    always_comb begin
        if (p_ovf) begin
            p_val = mneg_reg ? D_LO : D_HI;
        end else if (mneg_reg) begin
            p_val = -$signed(DW'(p_mag));
        end else begin
            p_val = $signed(DW'(p_mag));
        end
    end

    // Divider set-up and one restoring step
    assign dd     = {a_mag[DW-1:0], {F{1'b0}}};
    assign r_init = dd[DW+F-1:DW-1];
    assign trial  = {rem_reg, qsh_reg[DW-2]};
    assign ge     = trial >= {1'b0, b0_reg};

    // Quotient with zero-divisor and overflow handling
    always_comb begin
        if (b0_reg == '0) begin
            q_val = dzero_reg ? '0 : (dneg_reg ? D_LO : D_HI);
        end else if (dovf_reg) begin
            q_val = dneg_reg ? D_LO : D_HI;
        end else if (dneg_reg) begin
            q_val = -$signed({1'b0, qsh_reg});
        end else begin
            q_val = $signed({1'b0, qsh_reg});
        end
    end

    // Register next values
    always_comb begin
        z1_next    = z1_reg;
        z2_next    = z2_reg;
        u_next     = u_reg;
        r_next     = r_reg;
        y_next     = y_reg;
        e_next     = e_reg;
        t_next     = t_reg;
        b2_next    = b2_reg;
        err_next   = err_reg;
        mneg_next  = mneg_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        acc_next   = acc_reg;
        dneg_next  = dneg_reg;
        dzero_next = dzero_reg;
        dovf_next  = dovf_reg;
        rem_next   = rem_reg;
        qsh_next   = qsh_reg;
        cnt_next   = cnt_reg;

        // capture an item
        if (in_fire) begin
            r_next = sat_dw((OW+1)'(s_target_rate));
            y_next = sat_dw((OW+1)'(s_measured_rate));
        end

        // write back add, subtract and clamp results
        if (alu_wr) begin
            unique case (uc.dst)
                DST_Z1:  z1_next  = alu_res;
                DST_Z2:  z2_next  = alu_res;
                DST_U:   u_next   = alu_res;
                DST_E:   e_next   = alu_res;
                DST_T:   t_next   = alu_res;
                DST_B2:  b2_next  = alu_res;
                DST_ERR: err_next = alu_res;
                default: ;
            endcase
        end

        unique case (uc.op)
            OP_MULA: begin
                mneg_next = a_w[OW-1] ^ b_w[OW-1];
                ma_next   = a_mag;
                mb_next   = b_mag;
            end
            OP_MULL: acc_next = PW'(pp);
            OP_MULH: acc_next = acc_reg + (PW'(pp) << HW);
            OP_DIVI: begin
                dneg_next  = a_w[OW-1];
                dzero_next = (a_w == '0);
                dovf_next  = (32'(r_init) >= 32'(b0_reg));
                rem_next   = CFG_W'(r_init);
                qsh_next   = dd[DW-2:0];
                cnt_next   = CW'(DW - 1);
            end
            OP_DIVS: begin
                rem_next = ge ? CFG_W'(trial - {1'b0, b0_reg}) : trial[CFG_W-1:0];
                qsh_next = {qsh_reg[DW-3:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_CLR: begin
                z1_next  = '0;
                z2_next  = '0;
                u_next   = '0;
                err_next = '0;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        uo_next      = uo_reg;
        z1o_next     = z1o_reg;
        z2o_next     = z2o_reg;
        erro_next    = erro_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            uo_next      = out32(u_reg);
            z1o_next     = out32(z1_reg);
            z2o_next     = out32(z2_reg);
            erro_next    = out32(err_reg);
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_control_output       = uo_reg;
    assign m_rate_estimate        = z1o_reg;
    assign m_disturbance_estimate = z2o_reg;
    assign m_tracking_error       = erro_reg;

    // ------------------------------------------------------------------
    // Control state, loop state and configuration
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= UPC_IDLE;
            m_valid_reg <= 1'b0;
            z1_reg      <= '0;
            z2_reg      <= '0;
            u_reg       <= '0;
            ts_reg      <= DEF_STEP_TIME;
            b0_reg      <= DEF_PLANT_GAIN;
            wc_reg      <= DEF_CONTROL_BANDWIDTH;
            wo_reg      <= DEF_OBSERVER_BANDWIDTH;
            ol_reg      <= DEF_OUTPUT_LIMIT;
            dl_reg      <= DEF_DISTURBANCE_LIMIT;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            z1_reg      <= z1_next;
            z2_reg      <= z2_next;
            u_reg       <= u_next;
            // take a register write, drop unknown indexes
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_STEP_TIME:          ts_reg <= cfg_wdata;
                    REG_PLANT_GAIN:         b0_reg <= cfg_wdata;
                    REG_CONTROL_BANDWIDTH:  wc_reg <= cfg_wdata;
                    REG_OBSERVER_BANDWIDTH: wo_reg <= cfg_wdata;
                    REG_OUTPUT_LIMIT:       ol_reg <= cfg_wdata;
                    REG_DISTURBANCE_LIMIT:  dl_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Working registers, no reset
    always_ff @(posedge aclk) begin
        r_reg     <= r_next;
        y_reg     <= y_next;
        e_reg     <= e_next;
        t_reg     <= t_next;
        b2_reg    <= b2_next;
        err_reg   <= err_next;
        mneg_reg  <= mneg_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        acc_reg   <= acc_next;
        dneg_reg  <= dneg_next;
        dzero_reg <= dzero_next;
        dovf_reg  <= dovf_next;
        rem_reg   <= rem_next;
        qsh_reg   <= qsh_next;
        cnt_reg   <= cnt_next;
        uo_reg    <= uo_next;
        z1o_reg   <= z1o_next;
        z2o_reg   <= z2o_next;
        erro_reg  <= erro_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LADRC_ASSERT_NEXT(a_leave_idle, in_fire, !s_ready, "sequencer stayed idle after an item")
    `LADRC_ASSERT_NOW(a_div_count, uc.op == OP_DIVS, cnt_reg != '0, "divider step with no count")
    `LADRC_ASSERT_NOW(a_mul_order, uc.op == OP_MULH, $past(uc.op == OP_MULL), "high slice without low slice")
    `LADRC_ASSERT_NOW(a_emit_only, $rose(m_valid_reg), $past(uc.seq == SEQ_EMIT), "result outside emit step")

endmodule

@@ verif/ladrc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ladrc_checker
// Watches the configuration port and both item channels of the LADRC rate
// controller, keeps its own copy of the loop state, predicts the result of
// every accepted item and compares each result item field by field.
// ----------------------------------------------------------------------------
module ladrc_checker
    import ladrc_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_action,
    input  logic signed [31:0]    s_target_rate,
    input  logic signed [31:0]    s_measured_rate,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [31:0]    m_control_output,
    input  logic signed [31:0]    m_rate_estimate,
    input  logic signed [31:0]    m_disturbance_estimate,
    input  logic signed [31:0]    m_tracking_error,
    output int                    error_count,
    output int                    outstanding
);

    localparam logic ACTION_CLEAR = 1'b1;

    localparam longint DW_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    localparam longint DW_MIN = -DW_MAX - 1;

    typedef struct packed {
        logic signed [31:0] control_output;
        logic signed [31:0] rate_estimate;
        logic signed [31:0] disturbance_estimate;
        logic signed [31:0] tracking_error;
    } loop_result_t;

    // Configuration copy
    longint unsigned ts_q, b0_q, wc_q, wo_q, out_lim_q, dist_lim_q;
    // Loop state copy
    longint z1_q, z2_q, u_q;

    loop_result_t expected_outputs[$];

    function automatic longint saturate(longint v);
        if (v > DW_MAX) return DW_MAX;
        if (v < DW_MIN) return DW_MIN;
        return v;
    endfunction

    function automatic bit [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Apply the sign to a magnitude, saturating at the data range
    function automatic longint from_magnitude(bit neg, bit [63:0] m);
        if (m > 64'(DW_MAX)) return neg ? DW_MIN : DW_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Fixed-point product, magnitude truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        bit         neg;
        bit [127:0] prod;
        neg  = (a < 0) != (b < 0);
        prod = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        prod = prod >> FRAC_BITS;
        if (prod[127:64] != 0) return neg ? DW_MIN : DW_MAX;
        return from_magnitude(neg, prod[63:0]);
    endfunction

    // Fixed-point quotient, truncated toward zero; zero divisor saturates a nonzero numerator
    function automatic longint fx_div(longint n, longint unsigned d);
        bit        neg;
        bit [63:0] un, quo, rem;
        neg = n < 0;
        un  = magnitude(n);
        if (d == 0) begin
            if (n == 0) return 0;
            return neg ? DW_MIN : DW_MAX;
        end
        quo = un / d;
        rem = un % d;
        if (quo > ((64'd1 << (DATA_WIDTH - 1)) >> FRAC_BITS)) return neg ? DW_MIN : DW_MAX;
        return from_magnitude(neg, (quo << FRAC_BITS) + ((rem << FRAC_BITS) / d));
    endfunction

    function automatic longint clamp_sym(longint v, longint unsigned lim);
        longint l;
        l = (lim > 64'(DW_MAX)) ? DW_MAX : longint'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    function automatic logic [31:0] to_field(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Observer update and control law for one item; advances the loop state
    function automatic loop_result_t predict_control_update(
        logic act, logic signed [31:0] r_in, logic signed [31:0] y_in
    );
        longint       r, y, e, beta1, beta2, term, z1, z2, err, num, u;
        loop_result_t res;
        if (act == ACTION_CLEAR) begin
            z1_q = 0;
            z2_q = 0;
            u_q  = 0;
            res  = '0;
            return res;
        end
        r     = saturate(longint'(r_in));
        y     = saturate(longint'(y_in));
        z1    = z1_q;
        z2    = z2_q;
        e     = saturate(y - z1);
        beta1 = saturate(longint'(wo_q) * 2);
        beta2 = fx_mul(longint'(wo_q), longint'(wo_q));
        term  = saturate(z2 + fx_mul(longint'(b0_q), u_q));
        term  = saturate(term + fx_mul(beta1, e));
        z1    = saturate(z1 + fx_mul(longint'(ts_q), term));
        z2    = saturate(z2 + fx_mul(longint'(ts_q), fx_mul(beta2, e)));
        z2    = clamp_sym(z2, dist_lim_q);
        err   = saturate(r - z1);
        num   = saturate(fx_mul(longint'(wc_q), err) - z2);
        u     = clamp_sym(fx_div(num, b0_q), out_lim_q);
        z1_q  = z1;
        z2_q  = z2;
        u_q   = u;
        res.control_output       = to_field(u);
        res.rate_estimate        = to_field(z1);
        res.disturbance_estimate = to_field(z2);
        res.tracking_error       = to_field(err);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        // print the first hundred only
        if (error_count <= 100)
            $display("%0t ladrc_checker: %s: got %h, want %h", $time, what, got, want);
    endtask

    // Track configuration, predict on input items, compare result items
    always @(posedge aclk) begin
        loop_result_t want;
        if (!aresetn) begin
            ts_q       = DEF_STEP_TIME;
            b0_q       = DEF_PLANT_GAIN;
            wc_q       = DEF_CONTROL_BANDWIDTH;
            wo_q       = DEF_OBSERVER_BANDWIDTH;
            out_lim_q  = DEF_OUTPUT_LIMIT;
            dist_lim_q = DEF_DISTURBANCE_LIMIT;
            z1_q       = 0;
            z2_q       = 0;
            u_q        = 0;
            expected_outputs.delete();
            outstanding = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_STEP_TIME:          ts_q       = cfg_wdata;
                    REG_PLANT_GAIN:         b0_q       = cfg_wdata;
                    REG_CONTROL_BANDWIDTH:  wc_q       = cfg_wdata;
                    REG_OBSERVER_BANDWIDTH: wo_q       = cfg_wdata;
                    REG_OUTPUT_LIMIT:       out_lim_q  = cfg_wdata;
                    REG_DISTURBANCE_LIMIT:  dist_lim_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch("result item with none expected", m_control_output, '0);
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_control_output !== want.control_output)
                        report_mismatch("control_output", m_control_output,
                                        want.control_output);
                    if (m_rate_estimate !== want.rate_estimate)
                        report_mismatch("rate_estimate", m_rate_estimate,
                                        want.rate_estimate);
                    if (m_disturbance_estimate !== want.disturbance_estimate)
                        report_mismatch("disturbance_estimate", m_disturbance_estimate,
                                        want.disturbance_estimate);
                    if (m_tracking_error !== want.tracking_error)
                        report_mismatch("tracking_error", m_tracking_error,
                                        want.tracking_error);
                end
            end
            if (s_valid && s_ready)
                expected_outputs.push_back(
                    predict_control_update(s_action, s_target_rate, s_measured_rate));
            outstanding = expected_outputs.size();
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the LADRC rate controller with directed items at the field and
// register extremes, then with random control sequences under several
// register settings, random idling on both channels and one long output
// stall. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ladrc_pkg::*;

    localparam logic ACTION_STEP  = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic [CFG_W-1:0] CFG_MAX = 31'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] CFG_MIN = 31'd1;
    localparam logic [CFG_W-1:0] CFG_ZERO = 31'd0;

    localparam logic signed [31:0] RATE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RATE_MIN = 32'sh8000_0000;

    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 142;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_valid  = 1'b0;
    logic                  s_ready;
    logic                  s_action = 1'b0;
    logic signed [31:0]    s_target_rate   = '0;
    logic signed [31:0]    s_measured_rate = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_control_output;
    logic signed [31:0]    m_rate_estimate;
    logic signed [31:0]    m_disturbance_estimate;
    logic signed [31:0]    m_tracking_error;

    int error_count;
    int outstanding;

    // Stimulus control shared with the receiver
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int random_count = 0;

    // Slow plant used for well-formed sequences
    longint target_level = 0;
    longint plant_rate   = 0;

    first_order_ladrc_rate_controller i_dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_target_rate          (s_target_rate),
        .s_measured_rate        (s_measured_rate),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_control_output       (m_control_output),
        .m_rate_estimate        (m_rate_estimate),
        .m_disturbance_estimate (m_disturbance_estimate),
        .m_tracking_error       (m_tracking_error)
    );

    ladrc_checker i_checker (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_target_rate          (s_target_rate),
        .s_measured_rate        (s_measured_rate),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_control_output       (m_control_output),
        .m_rate_estimate        (m_rate_estimate),
        .m_disturbance_estimate (m_disturbance_estimate),
        .m_tracking_error       (m_tracking_error),
        .error_count            (error_count),
        .outstanding            (outstanding)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Give up after a generous fixed time
    initial begin
        #1_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // Result receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 400;
                m_ready      = 1'b0;
            end else begin
                m_ready = quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    function automatic logic signed [31:0] rate_q(int whole);
        return whole <<< 16;
    endfunction

    // Register value: mostly a plausible range, sometimes an extreme or any value
    function automatic logic [CFG_W-1:0] pick_setting(int unsigned lo, int unsigned hi);
        int unsigned       roll;
        logic [CFG_W-1:0]  raw;
        roll = $urandom_range(15);
        raw  = $urandom;
        if (roll == 0) return CFG_MIN;
        if (roll == 1) return CFG_MAX;
        if (roll < 5) return raw;
        return $urandom_range(hi, lo);
    endfunction

    // Offer one item and hold it until accepted; called and returns at a falling edge
    task automatic send_item(logic act, logic signed [31:0] r, logic signed [31:0] y);
        while (!quiet && ($urandom_range(99) < 7)) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_action        = act;
        s_target_rate   = r;
        s_measured_rate = y;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(logic [CFG_W-1:0] ts, logic [CFG_W-1:0] b0,
                             logic [CFG_W-1:0] wc, logic [CFG_W-1:0] wo,
                             logic [CFG_W-1:0] ol, logic [CFG_W-1:0] dl);
        write_reg(REG_STEP_TIME, ts);
        write_reg(REG_PLANT_GAIN, b0);
        write_reg(REG_CONTROL_BANDWIDTH, wc);
        write_reg(REG_OBSERVER_BANDWIDTH, wo);
        write_reg(REG_OUTPUT_LIMIT, ol);
        write_reg(REG_DISTURBANCE_LIMIT, dl);
    endtask

    // Drop valid and wait until every result is back and the sequencer is idle
    task automatic drain;
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Mostly well-formed control sequences, with clears and full-range noise
    task automatic run_random_phase(int n_items);
        int     roll;
        longint step;
        write_all(pick_setting(33, 3277), pick_setting(1 << 16, 100 << 16),
                  pick_setting(1 << 16, 50 << 16), pick_setting(2 << 16, 150 << 16),
                  pick_setting(10 << 16, 1000 << 16), pick_setting(100 << 16, 30000 << 16));
        for (int i = 0; i < n_items; i++) begin
            quiet = (random_count >= 300) && (random_count < 450);
            if (random_count == 600) hold_request = 1'b1;
            roll = $urandom_range(99);
            if (roll < 3) begin
                send_item(ACTION_CLEAR, $urandom, $urandom);
            end else if (roll < 15) begin
                send_item(ACTION_STEP, $urandom, $urandom);
            end else begin
                if ($urandom_range(19) == 0)
                    target_level = longint'($urandom_range(1000 << 16)) - (500 << 16);
                step = (target_level - plant_rate) / 8;
                plant_rate = plant_rate + step + longint'($urandom_range(2 << 16)) - (1 << 16);
                send_item(ACTION_STEP, target_level[31:0], plant_rate[31:0]);
            end
            random_count++;
        end
        quiet = 1'b0;
        drain();
    endtask

    // Stimulus and verdict
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: field extremes and clear
        send_item(ACTION_STEP, 0, 0);
        send_item(ACTION_STEP, rate_q(100), 0);
        send_item(ACTION_STEP, rate_q(100), rate_q(50));
        send_item(ACTION_STEP, RATE_MAX, RATE_MIN);
        send_item(ACTION_STEP, RATE_MIN, RATE_MAX);
        send_item(ACTION_STEP, RATE_MAX, RATE_MAX);
        send_item(ACTION_STEP, RATE_MIN, RATE_MIN);
        send_item(ACTION_CLEAR, RATE_MAX, RATE_MIN);
        send_item(ACTION_STEP, -rate_q(200), rate_q(10));
        send_item(ACTION_STEP, 0, -1);
        drain();

        // Every register at its largest value
        write_all(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
        send_item(ACTION_STEP, RATE_MAX, RATE_MIN);
        send_item(ACTION_STEP, RATE_MIN, RATE_MAX);
        send_item(ACTION_STEP, rate_q(1), 0);
        send_item(ACTION_CLEAR, 0, 0);
        send_item(ACTION_STEP, 0, RATE_MAX);
        drain();

        // Every register at its smallest value
        write_all(CFG_MIN, CFG_MIN, CFG_MIN, CFG_MIN, CFG_MIN, CFG_MIN);
        send_item(ACTION_STEP, RATE_MAX, RATE_MIN);
        send_item(ACTION_STEP, -1, 1);
        send_item(ACTION_STEP, RATE_MIN, RATE_MAX);
        send_item(ACTION_CLEAR, 0, 0);
        drain();

        // Zero plant gain and writes to unused indexes
        write_all(DEF_STEP_TIME, CFG_ZERO, DEF_CONTROL_BANDWIDTH, DEF_OBSERVER_BANDWIDTH,
                  DEF_OUTPUT_LIMIT, DEF_DISTURBANCE_LIMIT);
        write_reg(REG_UNUSED_6, CFG_MAX);
        write_reg(REG_UNUSED_7, $urandom);
        send_item(ACTION_CLEAR, 0, 0);
        send_item(ACTION_STEP, 0, 0);
        send_item(ACTION_STEP, RATE_MAX, 0);
        send_item(ACTION_STEP, RATE_MIN, 0);
        drain();

        // Random phases, each under fresh register settings
        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase(ITEMS_PER_PHASE);

        repeat (160) @(negedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
